// File: rtl/core/y2h_pkg.sv
package y2h_pkg;

  localparam int COORD_BITS = 13;
  localparam int COMP_BITS  = 8;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_INPUT_IS_RGB = 3'd0;
  localparam logic [2:0] REG_COLOR_MATRIX = 3'd1;
  localparam logic [2:0] REG_YUV_FULL     = 3'd2;
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd3;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd4;

  localparam logic [1:0] MTX_BT601  = 2'd0;
  localparam logic [1:0] MTX_BT2020 = 2'd1;

  // YUV->RGB coefficients, 1/1024 units
  localparam logic signed [11:0] KR_601   = 12'sd1436;
  localparam logic signed [11:0] KGU_601  = 12'sd352;
  localparam logic signed [11:0] KGV_601  = 12'sd731;
  localparam logic signed [11:0] KB_601   = 12'sd1815;
  localparam logic signed [11:0] KR_2020  = 12'sd1450;
  localparam logic signed [11:0] KGU_2020 = 12'sd164;
  localparam logic signed [11:0] KGV_2020 = 12'sd488;
  localparam logic signed [11:0] KB_2020  = 12'sd1714;
  localparam logic signed [11:0] KR_709   = 12'sd1613;
  localparam logic signed [11:0] KGU_709  = 12'sd192;
  localparam logic signed [11:0] KGV_709  = 12'sd480;
  localparam logic signed [11:0] KB_709   = 12'sd1900;

  // reciprocals for constant division: ceil(2^24/219), ceil(2^24/224), ceil(2^36/10000)
  localparam logic [16:0] Y_LIM_RECIP = 17'd76609;
  localparam logic [16:0] C_LIM_RECIP = 17'd74899;
  localparam logic [22:0] LUMA_RECIP  = 23'd6871948;

  localparam logic [13:0] LUMA_KR    = 14'd2126;
  localparam logic [13:0] LUMA_KG    = 14'd7152;
  localparam logic [13:0] LUMA_KB    = 14'd722;
  localparam logic [12:0] LUMA_ROUND = 13'd5000;

  localparam logic [7:0] HUE_SECTOR = 8'd43;
  localparam logic [7:0] HUE_BASE_R = 8'd0;
  localparam logic [7:0] HUE_BASE_G = 8'd85;
  localparam logic [7:0] HUE_BASE_B = 8'd171;

  localparam int DIV_NUM_W = 16;
  localparam int DIV_DEN_W = 8;

  typedef struct packed {
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [COMP_BITS-1:0]  comp_a;
    logic [COMP_BITS-1:0]  comp_b;
    logic [COMP_BITS-1:0]  comp_c;
  } y2h_in_t;

  typedef struct packed {
    logic                 valid_res;
    logic [COMP_BITS-1:0] hue;
    logic [COMP_BITS-1:0] saturation;
    logic [COMP_BITS-1:0] luma;
  } y2h_out_t;

  typedef struct packed {
    logic                  input_is_rgb;
    logic [1:0]            color_matrix;
    logic                  yuv_full;
    logic [COORD_BITS-1:0] frame_width;
    logic [COORD_BITS-1:0] frame_height;
  } y2h_cfg_t;

  // travels alongside the dividers
  typedef struct packed {
    logic       frm;
    logic       hue_zero;
    logic       sat_zero;
    logic       hue_neg;
    logic [7:0] hue_base;
    logic [7:0] luma;
  } y2h_side_t;

endpackage

// File: rtl/core/y2h_cfg_regs.sv
module y2h_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [y2h_pkg::PADDR_W-1:0]  paddr,
  input  logic [y2h_pkg::PDATA_W-1:0]  pwdata,
  output logic [y2h_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output y2h_pkg::y2h_cfg_t            cfg
);
  import y2h_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.input_is_rgb <= 1'b0;
      cfg.color_matrix <= MTX_BT601;
      cfg.yuv_full     <= 1'b1;
      cfg.frame_width  <= '0;
      cfg.frame_height <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_INPUT_IS_RGB: cfg.input_is_rgb <= pwdata[0];
        REG_COLOR_MATRIX: cfg.color_matrix <= pwdata[1:0];
        REG_YUV_FULL:     cfg.yuv_full     <= pwdata[0];
        REG_FRAME_WIDTH:  cfg.frame_width  <= pwdata[COORD_BITS-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_INPUT_IS_RGB: prdata[0]              = cfg.input_is_rgb;
      REG_COLOR_MATRIX: prdata[1:0]            = cfg.color_matrix;
      REG_YUV_FULL:     prdata[0]              = cfg.yuv_full;
      REG_FRAME_WIDTH:  prdata[COORD_BITS-1:0] = cfg.frame_width;
      REG_FRAME_HEIGHT: prdata[COORD_BITS-1:0] = cfg.frame_height;
      default: ;
    endcase
  end

endmodule

// File: rtl/core/y2h_color.sv
module y2h_color (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  y2h_pkg::y2h_in_t  in_data,
  input  y2h_pkg::y2h_cfg_t cfg,
  output logic              out_vld,
  output logic              out_frm,
  output logic [7:0]        out_r,
  output logic [7:0]        out_g,
  output logic [7:0]        out_b
);
  import y2h_pkg::*;

  // limited-range chroma: ((c-128)*255 +/- 112) / 224, toward zero
  function automatic logic signed [9:0] chroma_lim(input logic [7:0] c);
    logic signed [8:0] d;
    logic [7:0]        mag;
    logic [15:0]       num;
    logic [32:0]       prod;
    logic [7:0]        q;
    d    = $signed({1'b0, c}) - 9'sd128;
    mag  = d[8] ? 8'(-d) : d[7:0];
    num  = {mag, 8'd0} - 16'(mag) + 16'd112;
    prod = 33'(num) * 33'(C_LIM_RECIP);
    q    = prod[31:24];
    return d[8] ? -$signed({2'b00, q}) : $signed({2'b00, q});
  endfunction

  // divide by 1024 toward zero
  function automatic logic signed [12:0] div1024(input logic signed [22:0] p);
    logic signed [22:0] adj;
    adj = p[22] ? p + 23'sd1023 : p;
    return 13'(adj >>> 10);
  endfunction

  function automatic logic [7:0] sat8(input logic signed [13:0] v);
    if (v < 0) return 8'd0;
    if (v > 14'sd255) return 8'd255;
    return v[7:0];
  endfunction

  // stage A
  logic       vld_a, frm_a;
  logic [7:0] ca_a, cb_a, cc_a;

  always_ff @(posedge clk) begin
    if (rst) vld_a <= 1'b0;
    else if (en) vld_a <= in_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      frm_a <= (in_data.col < cfg.frame_width) && (in_data.row < cfg.frame_height);
      ca_a  <= in_data.comp_a;
      cb_a  <= in_data.comp_b;
      cc_a  <= in_data.comp_c;
    end
  end

  // stage B: range expansion
  logic [7:0]        yo;
  logic [15:0]       ynum;
  logic [32:0]       yprod;
  logic signed [9:0] ys_n, us_n, vs_n;
  logic              vld_b, frm_b;
  logic signed [9:0] ys_b, us_b, vs_b;
  logic [7:0]        ca_b, cb_b, cc_b;

  assign yo    = (ca_a < 8'd16) ? 8'd0 : ca_a - 8'd16;
  assign ynum  = {yo, 8'd0} - 16'(yo) + 16'd109;
  assign yprod = 33'(ynum) * 33'(Y_LIM_RECIP);

  always_comb begin
    if (cfg.yuv_full) begin
      ys_n = $signed({2'b00, ca_a});
      us_n = $signed({2'b00, cb_a}) - 10'sd128;
      vs_n = $signed({2'b00, cc_a}) - 10'sd128;
    end else begin
      ys_n = $signed({1'b0, yprod[32:24]});
      us_n = chroma_lim(cb_a);
      vs_n = chroma_lim(cc_a);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld_b <= 1'b0;
    else if (en) vld_b <= vld_a;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      frm_b <= frm_a;
      ys_b  <= ys_n;
      us_b  <= us_n;
      vs_b  <= vs_n;
      ca_b  <= ca_a;
      cb_b  <= cb_a;
      cc_b  <= cc_a;
    end
  end

  // stage C: matrix products
  logic signed [11:0] kr, kgu, kgv, kb;
  logic               vld_c, frm_c;
  logic signed [9:0]  ys_c;
  logic signed [21:0] pr_c, pgu_c, pgv_c, pb_c;
  logic [7:0]         ca_c, cb_c, cc_c;

  always_comb begin
    unique case (cfg.color_matrix)
      MTX_BT601: begin
        kr = KR_601; kgu = KGU_601; kgv = KGV_601; kb = KB_601;
      end
      MTX_BT2020: begin
        kr = KR_2020; kgu = KGU_2020; kgv = KGV_2020; kb = KB_2020;
      end
      default: begin
        kr = KR_709; kgu = KGU_709; kgv = KGV_709; kb = KB_709;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) vld_c <= 1'b0;
    else if (en) vld_c <= vld_b;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      frm_c <= frm_b;
      ys_c  <= ys_b;
      pr_c  <= kr * vs_b;
      pgu_c <= kgu * us_b;
      pgv_c <= kgv * vs_b;
      pb_c  <= kb * us_b;
      ca_c  <= ca_b;
      cb_c  <= cb_b;
      cc_c  <= cc_b;
    end
  end

  // stage D: scale, add luma, clamp; RGB input passes through
  logic signed [22:0] pg_sum;
  logic signed [13:0] r_s, g_s, b_s;

  assign pg_sum = 23'(pgu_c) + 23'(pgv_c);
  assign r_s    = 14'(ys_c) + 14'(div1024(23'(pr_c)));
  assign g_s    = 14'(ys_c) - 14'(div1024(pg_sum));
  assign b_s    = 14'(ys_c) + 14'(div1024(23'(pb_c)));

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= vld_c;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_frm <= frm_c;
      if (cfg.input_is_rgb) begin
        out_r <= ca_c;
        out_g <= cb_c;
        out_b <= cc_c;
      end else begin
        out_r <= sat8(r_s);
        out_g <= sat8(g_s);
        out_b <= sat8(b_s);
      end
    end
  end

endmodule

// File: rtl/core/y2h_hsv_prep.sv
module y2h_hsv_prep (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic                   in_frm,
  input  logic [7:0]             r,
  input  logic [7:0]             g,
  input  logic [7:0]             b,
  output logic                   out_vld,
  output logic [15:0]            sat_num,
  output logic [7:0]             sat_den,
  output logic [15:0]            hue_num,
  output logic [7:0]             hue_den,
  output y2h_pkg::y2h_side_t     side
);
  import y2h_pkg::*;

  // stage E: max/min, sector, luma sum
  logic [7:0]        mx, mn;
  logic signed [8:0] diff;
  logic [7:0]        base;
  logic              vld_e, frm_e, neg_e;
  logic [7:0]        mx_e, delta_e, mag_e, base_e;
  logic [21:0]       lsum_e;

  always_comb begin
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
  end

  always_comb begin
    priority if (mx == r) begin
      diff = $signed({1'b0, g}) - $signed({1'b0, b});
      base = HUE_BASE_R;
    end else if (mx == g) begin
      diff = $signed({1'b0, b}) - $signed({1'b0, r});
      base = HUE_BASE_G;
    end else begin
      diff = $signed({1'b0, r}) - $signed({1'b0, g});
      base = HUE_BASE_B;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld_e <= 1'b0;
    else if (en) vld_e <= in_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      frm_e   <= in_frm;
      mx_e    <= mx;
      delta_e <= mx - mn;
      neg_e   <= diff[8];
      mag_e   <= diff[8] ? 8'(-diff) : diff[7:0];
      base_e  <= base;
      lsum_e  <= 22'(LUMA_KR) * 22'(r) + 22'(LUMA_KG) * 22'(g)
               + 22'(LUMA_KB) * 22'(b) + 22'(LUMA_ROUND);
    end
  end

  // stage F: numerators, luma / 10000
  logic [44:0] lprod;

  assign lprod = 45'(lsum_e) * 45'(LUMA_RECIP);

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= vld_e;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      // delta*255 + max/2
      sat_num       <= {delta_e, 8'd0} - 16'(delta_e) + 16'(mx_e >> 1);
      sat_den       <= mx_e;
      hue_num       <= 16'(mag_e) * 16'(HUE_SECTOR);
      hue_den       <= delta_e;
      side.frm      <= frm_e;
      side.hue_zero <= (delta_e == 8'd0);
      side.sat_zero <= (mx_e == 8'd0);
      side.hue_neg  <= neg_e;
      side.hue_base <= base_e;
      side.luma     <= lprod[43:36];
    end
  end

endmodule

// File: rtl/core/y2h_div_pipe.sv
module y2h_div_pipe #(
  parameter int NUM_W  = y2h_pkg::DIV_NUM_W,
  parameter int DEN_W  = y2h_pkg::DIV_DEN_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  num_a,
  input  logic [DEN_W-1:0]  den_a,
  input  logic [NUM_W-1:0]  num_b,
  input  logic [DEN_W-1:0]  den_b,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_vld,
  output logic [NUM_W-1:0]  quo_a,
  output logic [NUM_W-1:0]  quo_b,
  output logic [SIDE_W-1:0] side_out
);

  // restoring division, one quotient bit per stage; quotient shifts in
  // where numerator bits shift out
  logic              vld    [NUM_W+1];
  logic [NUM_W-1:0]  nq_a   [NUM_W+1];
  logic [NUM_W-1:0]  nq_b   [NUM_W+1];
  logic [DEN_W-1:0]  rem_a  [NUM_W+1];
  logic [DEN_W-1:0]  rem_b  [NUM_W+1];
  logic [DEN_W-1:0]  dv_a   [NUM_W+1];
  logic [DEN_W-1:0]  dv_b   [NUM_W+1];
  logic [SIDE_W-1:0] sd     [NUM_W+1];

  assign vld[0]   = in_vld;
  assign nq_a[0]  = num_a;
  assign nq_b[0]  = num_b;
  assign rem_a[0] = '0;
  assign rem_b[0] = '0;
  assign dv_a[0]  = den_a;
  assign dv_b[0]  = den_b;
  assign sd[0]    = side_in;

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W:0] t_a, t_b;
    logic           ge_a, ge_b;

    assign t_a  = {rem_a[s], nq_a[s][NUM_W-1]};
    assign t_b  = {rem_b[s], nq_b[s][NUM_W-1]};
    assign ge_a = t_a >= {1'b0, dv_a[s]};
    assign ge_b = t_b >= {1'b0, dv_b[s]};

    always_ff @(posedge clk) begin
      if (rst) vld[s+1] <= 1'b0;
      else if (en) vld[s+1] <= vld[s];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_a[s+1] <= ge_a ? DEN_W'(t_a - {1'b0, dv_a[s]}) : t_a[DEN_W-1:0];
        rem_b[s+1] <= ge_b ? DEN_W'(t_b - {1'b0, dv_b[s]}) : t_b[DEN_W-1:0];
        nq_a[s+1]  <= {nq_a[s][NUM_W-2:0], ge_a};
        nq_b[s+1]  <= {nq_b[s][NUM_W-2:0], ge_b};
        dv_a[s+1]  <= dv_a[s];
        dv_b[s+1]  <= dv_b[s];
        sd[s+1]    <= sd[s];
      end
    end
  end

  assign out_vld  = vld[NUM_W];
  assign quo_a    = nq_a[NUM_W];
  assign quo_b    = nq_b[NUM_W];
  assign side_out = sd[NUM_W];

endmodule

// File: rtl/core/yuv_to_hsv_pixel_converter.sv
// Pipeline: 4 color stages, 2 HSV prep stages, 16 divider stages and
//   1 output register.
// Throughput: one pixel per cycle while the sink takes results; the
//   16-stage restoring divider pipeline for saturation and hue sets the depth, not the rate.
// Reset (rst, synchronous, active high) empties the pipeline and loads the
//   register defaults: YUV input, BT.601, full range, frame size 0.
module yuv_to_hsv_pixel_converter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  y2h_pkg::y2h_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output y2h_pkg::y2h_out_t            out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [y2h_pkg::PADDR_W-1:0]  paddr,
  input  logic [y2h_pkg::PDATA_W-1:0]  pwdata,
  output logic [y2h_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import y2h_pkg::*;

  y2h_cfg_t  cfg;

  // Whole pipeline advances together; it holds only when the output
  // register has a beat that the sink is not taking.
  logic      en;

  logic       c_vld, c_frm;
  logic [7:0] c_r, c_g, c_b;

  logic                 p_vld;
  logic [DIV_NUM_W-1:0] sat_num, hue_num;
  logic [DIV_DEN_W-1:0] sat_den, hue_den;
  y2h_side_t            p_side;

  logic                 d_vld;
  logic [DIV_NUM_W-1:0] sat_q, hue_q;
  y2h_side_t            d_side;

  logic [7:0] hq, hue_v;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  y2h_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // frame check, range expansion, matrix, clamp
  y2h_color u_color (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (in_valid),
    .in_data (in_data),
    .cfg     (cfg),
    .out_vld (c_vld),
    .out_frm (c_frm),
    .out_r   (c_r),
    .out_g   (c_g),
    .out_b   (c_b)
  );

  // max/min, hue sector, numerators, luma
  y2h_hsv_prep u_prep (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (c_vld),
    .in_frm  (c_frm),
    .r       (c_r),
    .g       (c_g),
    .b       (c_b),
    .out_vld (p_vld),
    .sat_num (sat_num),
    .sat_den (sat_den),
    .hue_num (hue_num),
    .hue_den (hue_den),
    .side    (p_side)
  );

  // saturation = sat_num / max, hue magnitude = 43*|diff| / delta
  y2h_div_pipe #(
    .NUM_W  (DIV_NUM_W),
    .DEN_W  (DIV_DEN_W),
    .SIDE_W ($bits(y2h_side_t))
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (p_vld),
    .num_a    (sat_num),
    .den_a    (sat_den),
    .num_b    (hue_num),
    .den_b    (hue_den),
    .side_in  (p_side),
    .out_vld  (d_vld),
    .quo_a    (sat_q),
    .quo_b    (hue_q),
    .side_out (d_side)
  );

  // hue wraps on the 256-step circle; sign applied after the unsigned divide
  assign hq    = hue_q[7:0];
  assign hue_v = d_side.hue_base + (d_side.hue_neg ? 8'(-hq) : hq);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= d_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!d_side.frm) begin
        // outside the frame: every field zero
        out_data <= '0;
      end else begin
        out_data.valid_res  <= 1'b1;
        out_data.hue        <= d_side.hue_zero ? 8'd0 : hue_v;
        out_data.saturation <= d_side.sat_zero ? 8'd0 : sat_q[7:0];
        out_data.luma       <= d_side.luma;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.valid_res |->
      out_data.hue == 8'd0 && out_data.saturation == 8'd0 && out_data.luma == 8'd0)
    else $error("out-of-frame result has nonzero fields");

  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturation == 8'd0 |-> out_data.hue == 8'd0)
    else $error("zero saturation with nonzero hue");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");
`endif

endmodule

// File: tb/yuv_to_hsv_pixel_converter_test.sv
`timescale 1ns / 100ps

module yuv_to_hsv_pixel_converter_test;
  import y2h_pkg::*;

  localparam int LATENCY    = 23;
  localparam int NUM_RANDOM = 1800;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic     in_valid = 1'b0;
  logic     in_ready;
  y2h_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  y2h_out_t out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  yuv_to_hsv_pixel_converter u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // shadow copy of the register file, kept in step with every APB write
  y2h_cfg_t shadow_cfg;

  // pixels waiting for the driver, and the HSV results they should produce
  y2h_in_t  pixel_queue[$];
  y2h_out_t hsv_expected[$];

  int      fail_count = 0;
  longint  cycle_count = 0;
  bit      long_hold = 1'b0;   // set by the stimulus to force a long receiver stall

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    fail_count++;
  endtask

  function automatic int clamp8(input int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // full pixel path: optional YUV->RGB, then hue / saturation / luma
  function automatic y2h_out_t predict_hsv(input y2h_in_t px, input y2h_cfg_t cfg);
    y2h_out_t res;
    int y, u, v, ys, us, vs, yo;
    int kr, kgu, kgv, kb;
    int r, g, b, mx, mn, delta;
    res = '0;
    if (px.col >= cfg.frame_width || px.row >= cfg.frame_height) return res;
    if (cfg.input_is_rgb) begin
      r = int'(px.comp_a); g = int'(px.comp_b); b = int'(px.comp_c);
    end else begin
      y = int'(px.comp_a); u = int'(px.comp_b); v = int'(px.comp_c);
      ys = y; us = u - 128; vs = v - 128;
      if (!cfg.yuv_full) begin
        // limited range: stretch 16..235 luma, 16..240 chroma, round half away
        yo = (y < 16) ? 0 : y - 16;
        ys = (yo * 255 + 109) / 219;
        us = ((u - 128) * 255 + ((u >= 128) ? 112 : -112)) / 224;
        vs = ((v - 128) * 255 + ((v >= 128) ? 112 : -112)) / 224;
      end
      case (cfg.color_matrix)
        MTX_BT601: begin
          kr = int'(KR_601); kgu = int'(KGU_601); kgv = int'(KGV_601); kb = int'(KB_601);
        end
        MTX_BT2020: begin
          kr = int'(KR_2020); kgu = int'(KGU_2020); kgv = int'(KGV_2020);
          kb = int'(KB_2020);
        end
        default: begin  // code 3 falls back to BT.709
          kr = int'(KR_709); kgu = int'(KGU_709); kgv = int'(KGV_709); kb = int'(KB_709);
        end
      endcase
      r = clamp8(ys + (kr * vs) / 1024);
      g = clamp8(ys - (kgu * us + kgv * vs) / 1024);
      b = clamp8(ys + (kb * us) / 1024);
    end
    mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
    mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
    delta = mx - mn;
    res.valid_res = 1'b1;
    res.luma = 8'((2126 * r + 7152 * g + 722 * b + 5000) / 10000);
    res.saturation = 8'((mx == 0) ? 0 : (delta * 255 + mx / 2) / mx);
    if (delta == 0) res.hue = 8'd0;
    else if (mx == r) res.hue = 8'((43 * (g - b) / delta + 256) % 256);
    else if (mx == g) res.hue = 8'((85 + 43 * (b - r) / delta) % 256);
    else res.hue = 8'((171 + 43 * (r - g) / delta) % 256);
    return res;
  endfunction

  // APB write: setup then access; pready is tied high
  task automatic write_reg(input logic [2:0] idx, input int unsigned value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00}); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_INPUT_IS_RGB: shadow_cfg.input_is_rgb = value[0];
      REG_COLOR_MATRIX: shadow_cfg.color_matrix = value[1:0];
      REG_YUV_FULL:     shadow_cfg.yuv_full     = value[0];
      REG_FRAME_WIDTH:  shadow_cfg.frame_width  = value[12:0];
      REG_FRAME_HEIGHT: shadow_cfg.frame_height = value[12:0];
      default: ;
    endcase
  endtask

  task automatic set_mode(input bit rgb, input logic [1:0] mtx, input bit full,
                          input int w, input int h);
    write_reg(REG_INPUT_IS_RGB, 32'(rgb));
    write_reg(REG_COLOR_MATRIX, 32'(mtx));
    write_reg(REG_YUV_FULL, 32'(full));
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  // expectations are made when the pixel is queued; config is stable per phase
  task automatic push_pixel(input int c, input int r, input int a, input int b, input int cc);
    y2h_in_t px;
    px.col = COORD_BITS'(c); px.row = COORD_BITS'(r);
    px.comp_a = COMP_BITS'(a); px.comp_b = COMP_BITS'(b); px.comp_c = COMP_BITS'(cc);
    pixel_queue.push_back(px);
    hsv_expected.push_back(predict_hsv(px, shadow_cfg));
  endtask

  // mostly in-frame coords, some outside, occasional full-range extremes
  task automatic push_random_pixel();
    int c, r;
    if ($urandom_range(0, 9) == 0) begin
      c = $urandom_range(0, 8191); r = $urandom_range(0, 8191);
    end else begin
      c = (shadow_cfg.frame_width  == 0) ? 0 : $urandom_range(0, shadow_cfg.frame_width - 1);
      r = (shadow_cfg.frame_height == 0) ? 0 : $urandom_range(0, shadow_cfg.frame_height - 1);
    end
    push_pixel(c, r, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  // wait for the pipe to drain before touching registers again
  task automatic drain();
    while (pixel_queue.size() != 0 || hsv_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // ---------------- driver ----------------
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        void'(pixel_queue.pop_front());
        send_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
      end
      if (!(in_valid && !in_ready)) begin
        // slot free: offer next pixel or idle out the drawn gap
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= pixel_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor / receiver ----------------
  int recv_gap = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    y2h_out_t want;
    cycle_count++;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (hsv_expected.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = hsv_expected.pop_front();
          if (out_data.valid_res !== want.valid_res)
            report_mismatch("valid_res", int'(out_data.valid_res), int'(want.valid_res));
          if (out_data.hue !== want.hue)
            report_mismatch("hue", int'(out_data.hue), int'(want.hue));
          if (out_data.saturation !== want.saturation)
            report_mismatch("saturation", int'(out_data.saturation), int'(want.saturation));
          if (out_data.luma !== want.luma)
            report_mismatch("luma", int'(out_data.luma), int'(want.luma));
        end
        recv_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
      end
      // long stall so the pipe fills and in_ready drops
      if (long_hold && hold_left == 0) hold_left = 300;
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) long_hold = 1'b0;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  initial begin
    int phase;
    int unsigned bits;
    shadow_cfg = '0;
    shadow_cfg.yuv_full = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset frame size is 0: every pixel lands outside
    push_pixel(0, 0, 255, 255, 255);
    drain();

    // directed: YUV extremes under limited range, BT.601
    set_mode(1'b0, MTX_BT601, 1'b0, 8191, 8191);
    push_pixel(0, 0, 0, 0, 0);
    push_pixel(8190, 8190, 255, 255, 255);
    push_pixel(1, 1, 16, 128, 128);
    push_pixel(2, 2, 235, 240, 16);
    push_pixel(3, 3, 81, 90, 240);
    push_pixel(8191, 0, 128, 128, 128);   // column on the edge: rejected
    push_pixel(0, 8191, 128, 128, 128);   // row on the edge: rejected
    drain();

    // unused matrix code 3 behaves as BT.709; full range
    set_mode(1'b0, 2'd3, 1'b1, 100, 50);
    push_pixel(99, 49, 128, 0, 255);
    push_pixel(0, 0, 255, 0, 0);
    push_pixel(100, 0, 10, 20, 30);
    drain();

    // RGB input: grey, primaries, black, hue wrap around red
    set_mode(1'b1, MTX_BT2020, 1'b0, 8191, 8191);
    push_pixel(5, 5, 0, 0, 0);
    push_pixel(5, 5, 200, 200, 200);
    push_pixel(5, 5, 255, 0, 0);
    push_pixel(5, 5, 0, 255, 0);
    push_pixel(5, 5, 0, 0, 255);
    push_pixel(5, 5, 255, 0, 10);
    push_pixel(5, 5, 255, 255, 255);
    push_pixel(5, 5, 1, 0, 0);
    drain();

    // random phases across all register settings
    for (phase = 0; phase < 12; phase++) begin
      bits = $urandom;
      set_mode(bits[0], bits[2:1], bits[3],
               (phase == 0) ? 8191 : (phase == 1) ? 0 : $urandom_range(1, 8191),
               (phase == 0) ? 8191 : (phase == 1) ? 1 : $urandom_range(1, 8191));
      if (phase == 3) long_hold = 1'b1;
      repeat (NUM_RANDOM / 12) push_random_pixel();
      drain();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
